FILE: rtl/core/packed_diagonal_idpcm_strip_assert.svh
// Assertion macros for the packed diagonal inverse DPCM strip block.
// Used by the top level; depends on nothing else.
`ifndef PACKED_DIAGONAL_IDPCM_STRIP_ASSERT_SVH
`define PACKED_DIAGONAL_IDPCM_STRIP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PDIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PDIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pdis_pkg.sv
// Shared constants, types and the prediction function of the strip block.
// Depends on nothing; the store, the reconstruction stage and the top level import it.
`timescale 1ns / 1ps

package pdis_pkg;

  localparam int MAX_STRIP_WORDS = 1024;
  localparam int MIN_STRIP_WORDS = 7;
  localparam int POS_W           = $clog2(MAX_STRIP_WORDS);
  localparam int FILL_W          = POS_W + 1;
  localparam int WPS_W           = 11;
  localparam int SHIFT_W         = 5;
  localparam int WORD_W          = 32;
  localparam int BYTE_W          = 8;
  localparam int CFG_INDEX_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_WORDS_PER_STRIP = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_SHIFT      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECODE_MASK     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REFERENCE_BYTE  = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [WPS_W-1:0]   WPS_RESET   = 11'd1024;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd1;
  localparam logic [WORD_W-1:0]  MASK_RESET  = 32'h7F7F7F7F;
  localparam logic [BYTE_W-1:0]  REF_RESET   = 8'h80;

  // Write request from the reconstruction stage to the strip store.
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // One accepted error word with its strip position.
  typedef struct packed {
    logic [WORD_W-1:0] err;
    logic [POS_W-1:0]  pos;
    logic              strip_end;
  } item_t;

  // P = ((A + C) >> 1) + A + C - B, all modulo 2^32.
  function automatic logic [WORD_W-1:0] pdis_predict(input logic [WORD_W-1:0] a,
                                                     input logic [WORD_W-1:0] b,
                                                     input logic [WORD_W-1:0] c);
    logic [WORD_W-1:0] sum_ac;
    sum_ac = a + c;
    return (sum_ac >> 1) + sum_ac - b;
  endfunction

endpackage

FILE: rtl/core/pdis_ifs.sv
// Valid/ready stream interfaces for the error input and the sample output.
// Depends on nothing.
`timescale 1ns / 1ps

interface pdis_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] error_word;
  logic        frame_start;

  modport source(output valid, output error_word, output frame_start, input ready);
  modport sink(input valid, input error_word, input frame_start, output ready);
endinterface

interface pdis_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_word;
  logic        strip_done;

  modport source(output valid, output sample_word, output strip_done, input ready);
  modport sink(input valid, input sample_word, input strip_done, output ready);
endinterface

FILE: rtl/core/pdis_store.sv
// Strip store: one byte per word position holding the bottom row of the previous strip.
// Depends on pdis_pkg. A fill count stands in for clearing the memory at frame start.
`timescale 1ns / 1ps

module pdis_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [pdis_pkg::POS_W-1:0]    rd_addr,
  input  logic                          clear,
  input  logic [pdis_pkg::BYTE_W-1:0]   ref_byte,
  input  pdis_pkg::store_wr_t           wr,
  output logic [pdis_pkg::BYTE_W-1:0]   rd_byte
);
  import pdis_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_STRIP_WORDS];
  logic [BYTE_W-1:0] mem_q;
  logic [BYTE_W-1:0] clear_ref;
  logic [FILL_W-1:0] fill;
  logic              use_ref;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Entries at or above the fill count were not written since the frame began.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      clear_ref <= REF_RESET;
      use_ref   <= 1'b1;
    end else begin
      if (rd_en) begin
        use_ref <= clear || ({1'b0, rd_addr} >= fill);
      end
      if (rd_en && clear) begin
        fill      <= '0;
        clear_ref <= ref_byte;
      end else if (wr.en && (fill <= {1'b0, wr.addr})) begin
        fill <= {1'b0, wr.addr} + FILL_W'(1);
      end
    end
  end

  assign rd_byte = use_ref ? clear_ref : mem_q;

endmodule

FILE: rtl/core/pdis_recon.sv
// Reconstruction stage: input register, prediction datapath, tail sequencing, result register.
// Depends on pdis_pkg and pdis_ifs.
`timescale 1ns / 1ps

module pdis_recon (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  pdis_pkg::item_t               item,
  input  logic [pdis_pkg::BYTE_W-1:0]   store_byte,
  input  logic [pdis_pkg::SHIFT_W-1:0]  edge_shift,
  input  logic [pdis_pkg::WORD_W-1:0]   decode_mask,
  input  logic [pdis_pkg::BYTE_W-1:0]   reference_byte,
  output logic                          take_ready,
  output pdis_pkg::store_wr_t           wr,
  pdis_out_if.source                    samples
);
  import pdis_pkg::*;

  localparam logic [1:0] PH_MAIN  = 2'd0;
  localparam logic [1:0] PH_TAIL0 = 2'd1;
  localparam logic [1:0] PH_TAIL1 = 2'd2;
  localparam logic [1:0] PH_TAIL2 = 2'd3;

  logic              s1_valid;
  item_t             s1;
  logic [1:0]        phase;
  logic [WORD_W-1:0] previous_word;
  logic [WORD_W-1:0] diagonal_word;
  logic [WORD_W-1:0] saved [3];
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              out_done;

  logic              fire;
  logic              item_done;
  logic              is_main;
  logic [WORD_W-1:0] r4;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] c;
  logic [WORD_W-1:0] e;
  logic [SHIFT_W-1:0] sh;
  logic [WORD_W-1:0] y;

  assign fire       = s1_valid && (!out_valid || samples.ready);
  assign is_main    = (phase == PH_MAIN);
  assign item_done  = (is_main && !s1.strip_end) || (phase == PH_TAIL2);
  assign take_ready = !s1_valid || (fire && item_done);
  assign r4         = {4{reference_byte}};

  always_comb begin
    if (is_main && (s1.pos == '0)) begin
      a = r4;
      b = r4;
    end else begin
      a = previous_word;
      b = diagonal_word;
    end
    c  = is_main ? {store_byte, a[WORD_W-1:8]} : {8'h00, a[WORD_W-1:8]};
    sh = edge_shift;
    case (phase)
      PH_MAIN: begin
        case (s1.pos)
          POS_W'(0): e = s1.err << 24;
          POS_W'(1): e = s1.err << 16;
          POS_W'(2): e = s1.err << 8;
          default: begin
            e  = s1.err;
            sh = SHIFT_W'(1);
          end
        endcase
      end
      PH_TAIL0: e = saved[0] >> 8;
      PH_TAIL1: e = saved[1] >> 16;
      PH_TAIL2: e = saved[2] >> 24;
      default:  e = s1.err;
    endcase
    y = ((pdis_predict(a, b, c) + e) >> sh) & decode_mask;
  end

  // Interior words write three entries behind; tail words fill the last three.
  always_comb begin
    wr.data = y[BYTE_W-1:0];
    if (is_main) begin
      wr.en   = fire && (s1.pos >= POS_W'(3));
      wr.addr = s1.pos - POS_W'(3);
    end else begin
      wr.en   = fire;
      wr.addr = s1.pos - POS_W'(2) + POS_W'(phase - PH_TAIL0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      phase     <= PH_MAIN;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
        phase    <= PH_MAIN;
      end else if (fire && item_done) begin
        s1_valid <= 1'b0;
      end else if (fire) begin
        phase <= phase + 2'd1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= item;
    end
    if (fire) begin
      previous_word <= y;
      diagonal_word <= c;
      out_word      <= y;
      out_done      <= (phase == PH_TAIL2);
      if (is_main && (s1.pos < POS_W'(3))) begin
        saved[s1.pos[1:0]] <= s1.err;
      end
    end
  end

  assign samples.valid       = out_valid;
  assign samples.sample_word = out_word;
  assign samples.strip_done  = out_done;

endmodule

FILE: rtl/core/packed_diagonal_idpcm_strip.sv
// Top level of the packed diagonal inverse DPCM strip block.
// Depends on pdis_pkg, pdis_ifs, pdis_store, pdis_recon and the assertion header.
`timescale 1ns / 1ps

// This block rebuilds one four-row strip of image samples from decoded error words, each
// 32-bit word being a four-pixel diagonal with the top row in the high byte. It takes one
// error transaction per clock cycle while the output is not stalled and no tail words are
// pending, and each passes through the stage register and the output register to become one
// sample transaction. After the last input of a strip the single reconstruction datapath
// produces three right-end words in turn, each built from the one before it, so the input
// side is held off meanwhile: a strip of W words takes W-3 inputs. The output register and
// the stage before it hold two words, so one more error transaction is taken while a result
// waits to be taken. The strip store is a 1024-byte memory; a frame start takes effect at once
// with no clearing pass, because a fill count makes entries not yet written in the new frame
// read as the reference byte captured at that start. Configuration is written through
// cfg_write, cfg_index and cfg_data, only while the block is idle: the user must keep to this,
// as the block does not enforce it; writes to indexes beyond the four registers are ignored.

`include "packed_diagonal_idpcm_strip_assert.svh"

module packed_diagonal_idpcm_strip (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pdis_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pdis_pkg::WORD_W-1:0]       cfg_data,
  pdis_in_if.sink                           errors,
  pdis_out_if.source                        samples
);
  import pdis_pkg::*;

  // Configuration registers.
  logic [WPS_W-1:0]   words_per_strip;
  logic [SHIFT_W-1:0] edge_shift;
  logic [WORD_W-1:0]  decode_mask;
  logic [BYTE_W-1:0]  reference_byte;

  // Position of the next input word within its strip.
  logic [POS_W-1:0]   word_position;

  logic               accept;
  logic               take_ready;
  logic [WPS_W-1:0]   w_sat;
  logic [POS_W-1:0]   last_pos;
  logic [POS_W-1:0]   p_cur;
  logic               end_cur;
  logic [BYTE_W-1:0]  store_byte;
  item_t              item;
  store_wr_t          wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_strip <= WPS_RESET;
      edge_shift      <= SHIFT_RESET;
      decode_mask     <= MASK_RESET;
      reference_byte  <= REF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WORDS_PER_STRIP: words_per_strip <= cfg_data[WPS_W-1:0];
        CFG_EDGE_SHIFT:      edge_shift      <= cfg_data[SHIFT_W-1:0];
        CFG_DECODE_MASK:     decode_mask     <= cfg_data;
        CFG_REFERENCE_BYTE:  reference_byte  <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The strip width is clamped into its legal range; the last input sits four words
  // before the end, since three tail words follow it.
  always_comb begin
    if (words_per_strip < WPS_W'(MIN_STRIP_WORDS)) begin
      w_sat = WPS_W'(MIN_STRIP_WORDS);
    end else if (words_per_strip > WPS_W'(MAX_STRIP_WORDS)) begin
      w_sat = WPS_W'(MAX_STRIP_WORDS);
    end else begin
      w_sat = words_per_strip;
    end
    last_pos = POS_W'(w_sat - WPS_W'(4));
  end

  assign accept       = errors.valid && take_ready;
  assign errors.ready = take_ready;

  // A frame start abandons any strip in progress and restarts at position zero.
  assign p_cur   = errors.frame_start ? '0 : word_position;
  assign end_cur = (p_cur >= last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
    end else if (accept) begin
      word_position <= end_cur ? '0 : p_cur + POS_W'(1);
    end
  end

  assign item.err       = errors.error_word;
  assign item.pos       = p_cur;
  assign item.strip_end = end_cur;

  // The store read is issued on the accepting edge, so its byte lines up with the item
  // once it sits in the reconstruction stage.
  pdis_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (p_cur),
    .clear    (accept && errors.frame_start),
    .ref_byte (reference_byte),
    .wr       (wr),
    .rd_byte  (store_byte)
  );

  pdis_recon u_recon (
    .clk            (clk),
    .rst            (rst),
    .take           (accept),
    .item           (item),
    .store_byte     (store_byte),
    .edge_shift     (edge_shift),
    .decode_mask    (decode_mask),
    .reference_byte (reference_byte),
    .take_ready     (take_ready),
    .wr             (wr),
    .samples        (samples)
  );

  // The last input of a strip must hold off the input side while its three tail
  // words are produced.
  `PDIS_ASSERT_NEXT(a_tail_blocks_input, clk, rst, accept && end_cur,
    !accept ##1 !accept ##1 !accept, "input accepted during strip tail words")

  // Within a frame, a store write never lands on the entry being read in the same cycle.
  // A frame start reads the reference byte instead, so it may share the entry.
  `PDIS_ASSERT_NOW(a_store_no_collision, clk, rst, accept && wr.en && !errors.frame_start,
    wr.addr != p_cur, "strip store read and write collide")

  // A frame start always begins a strip that runs past its first word.
  `PDIS_ASSERT_NEXT(a_frame_restart, clk, rst, accept && errors.frame_start,
    word_position == POS_W'(1), "frame start did not restart the strip position")

endmodule
